### design/assert_macros.svh
// Assertion macros used by the frame buffer pool allocator RTL.
// Expects signals named clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FBPA_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FBPA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/fbpa_pkg.sv
// Package for the frame buffer pool allocator: sizes, codes and the
// structs carried along the cell chain. No dependencies.
package fbpa_pkg;

  localparam int POOL_ENTRIES = 8;
  localparam int IDX_W        = 3;
  localparam int TAG_W        = 16;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 8;

  localparam logic [TAG_W-1:0] TAG_NONE  = 16'hFFFF;
  localparam logic [1:0]       PIC_BLANK = 2'd0;

  // Request kind, carried on in_tuser
  typedef enum logic [1:0] {
    FN_GET  = 2'd0,
    FN_PUT  = 2'd1,
    FN_MARK = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  // Entry ownership
  typedef enum logic [1:0] {
    USE_FREE    = 2'd0,
    USE_PREPARE = 2'd1,
    USE_CURRENT = 2'd2
  } use_t;

  // Update applied to one entry
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_CLAIM   = 3'd1,  // mark used, keep tag and picture
    CMD_RETAG   = 3'd2,  // mark used, new tag
    CMD_REPLACE = 3'd3,  // mark used, new tag, picture blanked
    CMD_PUT     = 3'd4,  // free, blank if untagged
    CMD_MARK    = 3'd5   // write picture state
  } cmd_op_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_LAUNCH = 3'd1,
    ST_SCAN   = 3'd2,
    ST_COMMIT = 3'd3,
    ST_REPORT = 3'd4
  } state_t;

  // Search record handed from cell to cell: first hit of each tier
  typedef struct packed {
    logic             active;
    logic             hit_tag;
    logic [IDX_W-1:0] idx_tag;
    logic             hit_blank;
    logic [IDX_W-1:0] idx_blank;
    logic             hit_free;
    logic [IDX_W-1:0] idx_free;
  } scan_t;

  // Update broadcast to all cells
  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    use_t             use_kind;
    logic [1:0]       pic;
  } cmd_t;

  // Spare count limited to the last pool entry
  function automatic logic [IDX_W-1:0] spares_clamp(input logic [IDX_W-1:0] s);
    logic [IDX_W-1:0] r;
    r = s;
    if (int'(s) > POOL_ENTRIES - 1) begin
      r = IDX_W'(POOL_ENTRIES - 1);
    end
    return r;
  endfunction

endpackage

### design/fbpa_cell.sv
// One pool entry of the allocator: tag, use and picture state, plus one
// stage of the search chain. Depends on fbpa_pkg.
module fbpa_cell
  import fbpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [IDX_W-1:0] spare_eff,
  input  logic             init_we,
  input  logic [IDX_W-1:0] init_fb,
  input  logic [TAG_W-1:0] scan_id,
  input  scan_t            scan_in,
  output scan_t            scan_out,
  input  cmd_t             cmd,
  output logic [1:0]       pic_out
);

  logic [TAG_W-1:0] tag_r, tag_nxt;
  use_t             use_r, use_nxt;
  logic [1:0]       pic_r, pic_nxt;
  scan_t            scan_r, scan_nxt;
  logic             in_pool;
  logic             is_free;

  assign in_pool = (cell_idx <= spare_eff);
  assign is_free = (use_r == USE_FREE);

  // Search stage: record the first hit of each tier
  always_comb begin
    scan_nxt = scan_in;
    if (scan_in.active && in_pool && is_free) begin
      if (!scan_in.hit_tag && (tag_r == scan_id)) begin
        scan_nxt.hit_tag = 1'b1;
        scan_nxt.idx_tag = cell_idx;
      end
      if (!scan_in.hit_blank && (pic_r == PIC_BLANK)) begin
        scan_nxt.hit_blank = 1'b1;
        scan_nxt.idx_blank = cell_idx;
      end
      if (!scan_in.hit_free) begin
        scan_nxt.hit_free = 1'b1;
        scan_nxt.idx_free = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan_out = scan_r;

  // Entry update: pool init first, then the addressed command
  always_comb begin
    tag_nxt = tag_r;
    use_nxt = use_r;
    pic_nxt = pic_r;
    if (init_we) begin
      tag_nxt = '0;
      pic_nxt = PIC_BLANK;
      use_nxt = ((init_fb != '0) && (cell_idx == init_fb)) ? USE_CURRENT : USE_FREE;
    end else if (cmd.idx == cell_idx) begin
      case (cmd.op)
        CMD_CLAIM: begin
          use_nxt = cmd.use_kind;
        end
        CMD_RETAG: begin
          tag_nxt = cmd.tag;
          use_nxt = cmd.use_kind;
        end
        CMD_REPLACE: begin
          tag_nxt = cmd.tag;
          use_nxt = cmd.use_kind;
          pic_nxt = PIC_BLANK;
        end
        CMD_PUT: begin
          use_nxt = USE_FREE;
          if (tag_r == TAG_NONE) begin
            pic_nxt = PIC_BLANK;
          end
        end
        CMD_MARK: begin
          pic_nxt = cmd.pic;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
      use_r <= USE_FREE;
      pic_r <= PIC_BLANK;
    end else begin
      tag_r <= tag_nxt;
      use_r <= use_nxt;
      pic_r <= pic_nxt;
    end
  end

  assign pic_out = pic_r;

endmodule

### design/fbpa_ctrl.sv
// Sequencer of the allocator: takes request beats, launches the search
// down the cell chain, picks the tier, commits and returns the result.
// Depends on fbpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_wdata,
  output logic [IDX_W-1:0]       spare_eff,
  output logic [TAG_W-1:0]       scan_id,
  output scan_t                  scan_head,
  input  scan_t                  scan_tail,
  output cmd_t                   cmd,
  input  logic [1:0]             cell_pic [POOL_ENTRIES]
);

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       spare_r;
  logic [TAG_W-1:0]       id_r;
  logic                   cur_r;
  logic [1:0]             pic_r;
  logic                   grant_r, grant_nxt;
  logic [IDX_W-1:0]       gidx_r, gidx_nxt;
  cmd_op_t                op_r, op_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                   out_tuser_r, out_tuser_nxt;
  logic                   in_beat;
  logic                   out_load;
  logic                   tgt_ok;

  assign spare_eff = spares_clamp(spare_r);
  assign scan_id   = id_r;
  assign in_beat   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_REPORT) && (!out_tvalid_r || out_tready);
  assign tgt_ok    = (in_tdata[19:17] <= spare_eff);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = (func_t'(in_tuser) == FN_GET) ? ST_LAUNCH : ST_COMMIT;
        end
      end
      ST_LAUNCH: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_tail.active) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: state_nxt = ST_REPORT;
      ST_REPORT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready        = 1'b0;
    scan_head        = '0;
    cmd.op           = CMD_NONE;
    cmd.idx          = gidx_r;
    cmd.tag          = id_r;
    cmd.use_kind     = cur_r ? USE_CURRENT : USE_PREPARE;
    cmd.pic          = pic_r;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_LAUNCH: scan_head.active = 1'b1;
      ST_COMMIT: cmd.op = op_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      spare_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        spare_r <= cfg_wdata;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_beat) begin
      id_r   <= in_tdata[15:0];
      cur_r  <= in_tdata[16];
      pic_r  <= in_tdata[21:20];
    end
  end

  // Decision: direct for put/mark, from the chain tail for get
  always_comb begin
    grant_nxt = grant_r;
    gidx_nxt  = gidx_r;
    op_nxt    = op_r;
    if (in_beat) begin
      grant_nxt = 1'b0;
      gidx_nxt  = in_tdata[19:17];
      op_nxt    = CMD_NONE;
      case (func_t'(in_tuser))
        FN_PUT: begin
          grant_nxt = tgt_ok;
          op_nxt    = tgt_ok ? CMD_PUT : CMD_NONE;
        end
        FN_MARK: begin
          grant_nxt = tgt_ok;
          op_nxt    = tgt_ok ? CMD_MARK : CMD_NONE;
        end
        default: begin
        end
      endcase
    end else if ((state_r == ST_SCAN) && scan_tail.active) begin
      if (scan_tail.hit_tag) begin
        grant_nxt = 1'b1;
        gidx_nxt  = scan_tail.idx_tag;
        op_nxt    = CMD_CLAIM;
      end else if (scan_tail.hit_blank) begin
        grant_nxt = 1'b1;
        gidx_nxt  = scan_tail.idx_blank;
        op_nxt    = CMD_RETAG;
      end else if (scan_tail.hit_free) begin
        grant_nxt = 1'b1;
        gidx_nxt  = scan_tail.idx_free;
        op_nxt    = CMD_REPLACE;
      end else if (cur_r) begin
        // pool exhausted: steal entry 0
        grant_nxt = 1'b1;
        gidx_nxt  = '0;
        op_nxt    = CMD_REPLACE;
      end else begin
        grant_nxt = 1'b0;
        gidx_nxt  = '0;
        op_nxt    = CMD_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grant_r <= 1'b0;
      gidx_r  <= '0;
      op_r    <= CMD_NONE;
    end else begin
      grant_r <= grant_nxt;
      gidx_r  <= gidx_nxt;
      op_r    <= op_nxt;
    end
  end

  // Result register: holds a beat until taken
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tuser_nxt  = grant_r;
      if (grant_r) begin
        out_tdata_nxt = {2'b00, cell_pic[gidx_r], (gidx_r == spare_eff), gidx_r};
      end else begin
        out_tdata_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Checks
  `FBPA_ASSERT_IMPLY(a_tail_only_in_scan, scan_tail.active, state_r == ST_SCAN, "stray search")
  `FBPA_ASSERT_IMPLY(a_nogrant_zero, out_tvalid_r && !out_tuser_r, out_tdata_r == '0, "denied data")
  `FBPA_ASSERT_NEXT(a_commit_then_report, state_r == ST_COMMIT, state_r == ST_REPORT, "no report")
  `FBPA_ASSERT_NEXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r != ST_IDLE, "beat lost")

endmodule

### design/frame_buffer_pool_allocator_top.sv
// Frame buffer pool allocator, top level: one controller and a chain of
// eight entry cells. Depends on fbpa_pkg, fbpa_cell and fbpa_ctrl.
//
// One request beat is taken at a time. A get walks a search record
// through all eight cells, one cell per cycle, then commits and reports.
// A put or a picture-state mark needs no search. Writing spare_count
// re-initializes every entry in the same cycle. The result sits in an
// output register until taken.
module frame_buffer_pool_allocator_top
  import fbpa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] content_id, [16] for_current, [19:17] target_index,
  // [21:20] new_pic_state, [23:22] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] granted_index, [3] is_device_fb, [5:4] content_state, [7:6] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] granted
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_wdata
);

  logic [IDX_W-1:0] spare_eff;
  logic [IDX_W-1:0] init_fb;
  logic [TAG_W-1:0] scan_id;
  scan_t            scan_link [POOL_ENTRIES+1];
  cmd_t             cmd;
  logic [1:0]       cell_pic [POOL_ENTRIES];

  assign init_fb = spares_clamp(cfg_wdata);

  fbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .spare_eff  (spare_eff),
    .scan_id    (scan_id),
    .scan_head  (scan_link[0]),
    .scan_tail  (scan_link[POOL_ENTRIES]),
    .cmd        (cmd),
    .cell_pic   (cell_pic)
  );

  // Entry chain, search record flows from entry 0 upward
  for (genvar g = 0; g < POOL_ENTRIES; g++) begin : g_cell
    fbpa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .spare_eff (spare_eff),
      .init_we   (cfg_we),
      .init_fb   (init_fb),
      .scan_id   (scan_id),
      .scan_in   (scan_link[g]),
      .scan_out  (scan_link[g+1]),
      .cmd       (cmd),
      .pic_out   (cell_pic[g])
    );
  end

endmodule
